// ===== design/mmsc_pkg.sv =====
// shared types, constants and decode functions of the multicycle mips subset core
package mmsc_pkg;

	localparam int MEM_WORDS = 256;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int RF_WORDS  = 32;
	localparam int RF_AW     = $clog2(RF_WORDS);

	typedef enum logic [1:0] {
		OP_LOAD_MEM  = 2'd0,
		OP_WRITE_REG = 2'd1,
		OP_RUN       = 2'd2
	} op_t;

	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_SW    = 6'h2b;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_J     = 6'h02;

	localparam logic [3:0] FN_ADD = 4'h0;
	localparam logic [3:0] FN_SUB = 4'h2;
	localparam logic [3:0] FN_AND = 4'h4;
	localparam logic [3:0] FN_OR  = 4'h5;
	localparam logic [3:0] FN_SLT = 4'hA;

	typedef enum logic [9:0] {
		ST_FETCH     = 10'b00_0000_0001,
		ST_DECODE    = 10'b00_0000_0010,
		ST_MEM_ADDR  = 10'b00_0000_0100,
		ST_MEM_READ  = 10'b00_0000_1000,
		ST_MEM_WB    = 10'b00_0001_0000,
		ST_MEM_WRITE = 10'b00_0010_0000,
		ST_EXEC      = 10'b00_0100_0000,
		ST_R_WB      = 10'b00_1000_0000,
		ST_BRANCH    = 10'b01_0000_0000,
		ST_JUMP      = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  addr;
		logic [31:0] data;
	} item_t;

	typedef struct packed {
		logic        halted;
		logic [31:0] alu_result;
		logic [15:0] control_word;
		logic [3:0]  fsm_state_out;
		logic [31:0] pc_value;
	} status_t;

	function automatic state_t next_state(state_t st, logic [31:0] ir);
		state_t ns;
		ns = st;
		if (ir == '1) begin
			ns = ST_FETCH;
		end else if (st == ST_FETCH) begin
			ns = ST_DECODE;
		end else begin
			unique case (ir[31:26])
				OPC_RTYPE: begin
					if (st == ST_DECODE) ns = ST_EXEC;
					else if (st == ST_EXEC) ns = ST_R_WB;
					else if (st == ST_R_WB) ns = ST_FETCH;
				end
				OPC_LW: begin
					if (st == ST_DECODE) ns = ST_MEM_ADDR;
					else if (st == ST_MEM_ADDR) ns = ST_MEM_READ;
					else if (st == ST_MEM_READ) ns = ST_MEM_WB;
					else if (st == ST_MEM_WB) ns = ST_FETCH;
				end
				OPC_SW: begin
					if (st == ST_DECODE) ns = ST_MEM_ADDR;
					else if (st == ST_MEM_ADDR) ns = ST_MEM_WRITE;
					else if (st == ST_MEM_WRITE) ns = ST_FETCH;
				end
				OPC_BEQ: begin
					if (st == ST_DECODE) ns = ST_BRANCH;
					else if (st == ST_BRANCH) ns = ST_FETCH;
				end
				OPC_J: begin
					if (st == ST_DECODE) ns = ST_JUMP;
					else if (st == ST_JUMP) ns = ST_FETCH;
				end
				default: ns = st;
			endcase
		end
		return ns;
	endfunction

	function automatic logic [15:0] ctl_word(state_t st);
		logic [15:0] w;
		unique case (st)
			ST_FETCH:     w = 16'h9408;
			ST_DECODE:    w = 16'h9418;
			ST_MEM_ADDR:  w = 16'h9414;
			ST_MEM_READ:  w = 16'h9C14;
			ST_MEM_WB:    w = 16'h9C17;
			ST_MEM_WRITE: w = 16'hBC18;
			ST_EXEC:      w = 16'h9444;
			ST_R_WB:      w = 16'h9447;
			ST_BRANCH:    w = 16'h96A4;
			ST_JUMP:      w = 16'h9518;
			default:      w = 16'h9408;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] state_num(state_t st);
		logic [3:0] n;
		unique case (st)
			ST_FETCH:     n = 4'd0;
			ST_DECODE:    n = 4'd1;
			ST_MEM_ADDR:  n = 4'd2;
			ST_MEM_READ:  n = 4'd3;
			ST_MEM_WB:    n = 4'd4;
			ST_MEM_WRITE: n = 4'd5;
			ST_EXEC:      n = 4'd6;
			ST_R_WB:      n = 4'd7;
			ST_BRANCH:    n = 4'd8;
			ST_JUMP:      n = 4'd9;
			default:      n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== design/mmsc_core.sv =====
// architectural state, memories and one-request execution of the cpu
module mmsc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  mmsc_pkg::item_t  item,
	output mmsc_pkg::status_t status
);
	import mmsc_pkg::*;

	logic [31:0] pc_q, ir_q, a_q, b_q, alu_q, mdr_q;
	state_t      st_q;
	logic        halt_q;

	logic [31:0] pc_n, ir_n, a_n, b_n, alu_n, mdr_n;
	state_t      st_n;
	logic        halt_n;

	logic [31:0] mem [MEM_WORDS];
	logic [31:0] mem_rdata_q, mem_byp_data_q, mem_rd;
	logic        mem_byp_q, mem_we;
	logic [MEM_AW-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;

	logic [31:0] rf [RF_WORDS];
	logic [RF_WORDS-1:0] rf_vld_q;
	logic [31:0] rf_a_q, rf_b_q, rf_byp_data_q, rf_rd_a, rf_rd_b;
	logic        rf_va_q, rf_vb_q, rf_byp_a_q, rf_byp_b_q, rf_we;
	logic [RF_AW-1:0] rf_wa, rf_ra_a, rf_ra_b;
	logic [31:0] rf_wd;

	logic [31:0] imm_sext, br_diff;
	state_t      rd_ns;

	assign imm_sext = {{16{ir_q[15]}}, ir_q[15:0]};
	assign br_diff  = a_q - b_q;
	assign mem_rd   = mem_byp_q ? mem_byp_data_q : mem_rdata_q;
	assign rf_rd_a  = rf_byp_a_q ? rf_byp_data_q : (rf_va_q ? rf_a_q : 32'd0);
	assign rf_rd_b  = rf_byp_b_q ? rf_byp_data_q : (rf_vb_q ? rf_b_q : 32'd0);

	always_comb begin
		pc_n   = pc_q;
		ir_n   = ir_q;
		a_n    = a_q;
		b_n    = b_q;
		alu_n  = alu_q;
		mdr_n  = mdr_q;
		st_n   = st_q;
		halt_n = halt_q;
		mem_we = 1'b0;
		mem_wa = alu_q[MEM_AW-1:0];
		mem_wd = b_q;
		rf_we  = 1'b0;
		rf_wa  = ir_q[20:16];
		rf_wd  = mdr_q;
		if (fire) begin
			case (item.op)
				OP_LOAD_MEM: begin
					if (32'(item.addr) < MEM_WORDS) begin
						mem_we = 1'b1;
						mem_wa = MEM_AW'(item.addr);
						mem_wd = item.data;
					end
				end
				OP_WRITE_REG: begin
					if (32'(item.addr) < RF_WORDS && item.addr[RF_AW-1:0] != '0) begin
						rf_we = 1'b1;
						rf_wa = item.addr[RF_AW-1:0];
						rf_wd = item.data;
					end
				end
				OP_RUN: begin
					if (!halt_q) begin
						if (ir_q == 32'd0) halt_n = 1'b1;
						st_n = next_state(st_q, ir_q);
						unique case (st_n)
							ST_FETCH: begin
								ir_n = mem_rd;
								pc_n = pc_q + 32'd1;
							end
							ST_DECODE: begin
								a_n   = rf_rd_a;
								b_n   = rf_rd_b;
								alu_n = pc_q + imm_sext;
							end
							ST_MEM_ADDR: alu_n = a_q + imm_sext;
							ST_MEM_READ: mdr_n = mem_rd;
							ST_MEM_WB: begin
								rf_we = ir_q[20:16] != '0;
								rf_wa = ir_q[20:16];
								rf_wd = mdr_q;
							end
							ST_MEM_WRITE: mem_we = 1'b1;
							ST_EXEC: begin
								case (ir_q[3:0])
									FN_ADD: alu_n = a_q + b_q;
									FN_SUB: alu_n = br_diff;
									FN_AND: alu_n = a_q & b_q;
									FN_OR:  alu_n = a_q | b_q;
									FN_SLT: alu_n = {31'd0, $signed(a_q) < $signed(b_q)};
									default: alu_n = alu_q;
								endcase
							end
							ST_R_WB: begin
								rf_we = ir_q[15:11] != '0;
								rf_wa = ir_q[15:11];
								rf_wd = alu_q;
							end
							ST_BRANCH: begin
								alu_n = br_diff;
								if (br_diff == 32'd0) pc_n = alu_q;
							end
							ST_JUMP: pc_n = {pc_q[31:28], 2'b00, ir_q[25:0]};
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// reads issued now serve the next request, from the state it will see
	always_comb begin
		rd_ns   = next_state(st_n, ir_n);
		mem_ra  = (rd_ns == ST_FETCH) ? pc_n[MEM_AW-1:0] : alu_n[MEM_AW-1:0];
		rf_ra_a = ir_n[25:21];
		rf_ra_b = ir_n[20:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			ir_q   <= '1;
			a_q    <= '0;
			b_q    <= '0;
			alu_q  <= '0;
			mdr_q  <= '0;
			st_q   <= ST_FETCH;
			halt_q <= 1'b0;
		end else begin
			pc_q   <= pc_n;
			ir_q   <= ir_n;
			a_q    <= a_n;
			b_q    <= b_n;
			alu_q  <= alu_n;
			mdr_q  <= mdr_n;
			st_q   <= st_n;
			halt_q <= halt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rdata_q    <= mem[mem_ra];
		mem_byp_data_q <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf[rf_wa] <= rf_wd;
		rf_a_q        <= rf[rf_ra_a];
		rf_b_q        <= rf[rf_ra_b];
		rf_byp_data_q <= rf_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_byp_q  <= 1'b0;
			rf_vld_q   <= '0;
			rf_va_q    <= 1'b0;
			rf_vb_q    <= 1'b0;
			rf_byp_a_q <= 1'b0;
			rf_byp_b_q <= 1'b0;
		end else begin
			mem_byp_q  <= mem_we && (mem_wa == mem_ra);
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
			rf_va_q    <= rf_vld_q[rf_ra_a];
			rf_vb_q    <= rf_vld_q[rf_ra_b];
			rf_byp_a_q <= rf_we && (rf_wa == rf_ra_a);
			rf_byp_b_q <= rf_we && (rf_wa == rf_ra_b);
		end
	end

	always_comb begin
		status.pc_value      = pc_n;
		status.fsm_state_out = state_num(st_n);
		status.control_word  = ctl_word(st_n);
		status.alu_result    = alu_n;
		status.halted        = halt_n;
	end

endmodule

// ===== design/multicycle_mips_subset_core_top.sv =====
// top level of the multicycle mips subset core with stream handshakes
// Each request (load a memory word, write a register, or run one cpu clock) is
// taken into an input register and executed when the output register is free
// or being drained; its result lands in that output register, so one request
// per cycle is sustained while m_tready does not stall the output. The 256-word
// memory and the 32-entry register file have registered reads; each cycle they
// are read at the addresses the next request will need, with forwarding of a
// write made in the same cycle, which is what keeps the single-cycle rate.
module multicycle_mips_subset_core_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // address[7:0], data[39:8]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata   // pc_value, fsm_state_out, control_word, alu_result, halted
);
	import mmsc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    fire;
	status_t status;
	logic    m_tvalid_q;
	status_t out_q;

	assign fire     = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (fire) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op   <= s_tuser;
			item_s1.addr <= s_tdata[7:0];
			item_s1.data <= s_tdata[39:8];
		end
		if (fire) out_q <= status;
	end

	mmsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.status (status)
	);

endmodule
